>>> hdl/fcr_pkg.sv
// Package for the framed command receiver: result kinds, frame phases,
// config and result structs, checksum step. No dependencies.
package fcr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned REG_IDX_W = 2;

    // Register indexes on the APB port (byte address 4*index)
    localparam logic [REG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CODE_LIMIT  = 2'd2;

    localparam logic [BYTE_W-1:0] CODE_LIMIT_RST = 8'd128;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_OK  = 2'd1,
        KIND_BAD_CMD   = 2'd2,
        KIND_CSUM_ERR  = 2'd3
    } t_kind;

    // Frame phases, one-hot
    typedef enum logic [5:0] {
        ST_SYNC1 = 6'b000001,
        ST_SYNC2 = 6'b000010,
        ST_SEQ   = 6'b000100,
        ST_LEN   = 6'b001000,
        ST_BODY  = 6'b010000,
        ST_CSUM  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] code_limit;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_seq;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] data_size;
    } t_result;

    // One checksum step: rotate left by 3, then XOR in the byte
    function automatic logic [BYTE_W-1:0] sum_add(input logic [BYTE_W-1:0] sum,
                                                  input logic [BYTE_W-1:0] b);
        sum_add = {sum[4:0], sum[7:5]} ^ b;
    endfunction

endpackage

>>> hdl/fcr_rx_if.sv
// Valid/ready channel carrying one received byte per request.
// Depends on fcr_pkg for the byte width.
interface fcr_rx_if;
    import fcr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hdl/fcr_res_if.sv
// Valid/ready channel carrying one result request (payload or status).
// Depends on fcr_pkg for field widths.
interface fcr_res_if;
    import fcr_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] frame_seq;
    logic [BYTE_W-1:0] command_code;
    logic [BYTE_W-1:0] data_size;

    modport source (output valid, output kind, output payload_byte, output byte_index,
                    output frame_seq, output command_code, output data_size,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input byte_index,
                    input frame_seq, input command_code, input data_size,
                    output ready);
endinterface

>>> hdl/fcr_apb_regs.sv
// APB register bank: sync_first, sync_second, code_limit.
// Depends on fcr_pkg (t_cfg, register indexes, widths).
module fcr_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcr_pkg::PADDR_W-1:0]  paddr,
    input  logic [fcr_pkg::PDATA_W-1:0]  pwdata,
    output logic [fcr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output fcr_pkg::t_cfg                o_cfg
);
    import fcr_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [BYTE_W-1:0]    rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= '0;
            r_cfg.sync_second <= '0;
            r_cfg.code_limit  <= CODE_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= pwdata[BYTE_W-1:0];
                REG_SYNC_SECOND: r_cfg.sync_second <= pwdata[BYTE_W-1:0];
                REG_CODE_LIMIT:  r_cfg.code_limit  <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_SYNC_FIRST:  rd_byte = r_cfg.sync_first;
            REG_SYNC_SECOND: rd_byte = r_cfg.sync_second;
            REG_CODE_LIMIT:  rd_byte = r_cfg.code_limit;
            default:         rd_byte = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-BYTE_W){1'b0}}, rd_byte};
    assign o_cfg  = r_cfg;
endmodule

>>> hdl/fcr_frame_fsm.sv
// Frame phase machine and running checksum; one byte per request,
// result produced combinationally. Depends on fcr_pkg.
module fcr_frame_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fcr_pkg::t_cfg               i_cfg,
    input  logic                        i_take,
    input  logic [fcr_pkg::BYTE_W-1:0]  i_byte,
    output logic                        o_res_vld,
    output fcr_pkg::t_result            o_res
);
    import fcr_pkg::*;

    t_phase            r_phase,    n_phase;
    logic [BYTE_W-1:0] r_seq,      n_seq;
    logic [BYTE_W-1:0] r_len,      n_len;
    logic [BYTE_W-1:0] r_body_cnt, n_body_cnt;
    logic [BYTE_W-1:0] r_sum,      n_sum;
    logic [BYTE_W-1:0] r_code,     n_code;

    logic [BYTE_W-1:0] step_sum;
    logic [BYTE_W-1:0] cnt_inc;
    logic              len_zero;

    assign step_sum = sum_add(r_sum, i_byte);
    assign cnt_inc  = r_body_cnt + 8'd1;
    assign len_zero = (r_len == '0);

    // Next state and result
    always_comb begin
        n_phase    = r_phase;
        n_seq      = r_seq;
        n_len      = r_len;
        n_body_cnt = r_body_cnt;
        n_sum      = r_sum;
        n_code     = r_code;
        o_res_vld  = 1'b0;
        o_res.kind         = KIND_PAYLOAD;
        o_res.payload_byte = '0;
        o_res.byte_index   = '0;
        o_res.frame_seq    = r_seq;
        o_res.command_code = len_zero ? '0 : r_code;
        o_res.data_size    = '0;

        case (r_phase)
            ST_SYNC1: begin
                if (i_byte == i_cfg.sync_first) n_phase = ST_SYNC2;
            end
            ST_SYNC2: begin
                // second sync wins; a repeated first sync keeps waiting
                if (i_byte == i_cfg.sync_second) n_phase = ST_SEQ;
                else if (i_byte != i_cfg.sync_first) n_phase = ST_SYNC1;
            end
            ST_SEQ: begin
                n_seq   = i_byte;
                n_phase = ST_LEN;
            end
            ST_LEN: begin
                n_len      = i_byte;
                n_body_cnt = '0;
                n_sum      = '0;
                n_phase    = (i_byte != '0) ? ST_BODY : ST_CSUM;
            end
            ST_BODY: begin
                n_sum = step_sum;
                if (r_body_cnt == '0) begin
                    n_code = i_byte;
                end else begin
                    o_res_vld          = 1'b1;
                    o_res.payload_byte = i_byte;
                    o_res.byte_index   = r_body_cnt - 8'd1;
                end
                n_body_cnt = cnt_inc;
                if (cnt_inc >= r_len) n_phase = ST_CSUM;
            end
            ST_CSUM: begin
                n_sum           = step_sum;
                n_phase         = ST_SYNC1;
                o_res_vld       = 1'b1;
                o_res.data_size = len_zero ? '0 : r_len - 8'd1;
                if (step_sum != '0)
                    o_res.kind = KIND_CSUM_ERR;
                else if (len_zero || r_code == '0 || r_code >= i_cfg.code_limit)
                    o_res.kind = KIND_BAD_CMD;
                else
                    o_res.kind = KIND_FRAME_OK;
            end
            default: begin
                n_phase = ST_SYNC1;
            end
        endcase
    end

    // State registers, advanced on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ST_SYNC1;
            r_seq      <= '0;
            r_len      <= '0;
            r_body_cnt <= '0;
            r_sum      <= '0;
            r_code     <= '0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_seq      <= n_seq;
            r_len      <= n_len;
            r_body_cnt <= n_body_cnt;
            r_sum      <= n_sum;
            r_code     <= n_code;
        end
    end
endmodule

>>> hdl/framed_command_receiver_unit.sv
// Top level of the framed command receiver: APB registers, frame machine,
// output register with skid stage. Depends on fcr_pkg, fcr_rx_if, fcr_res_if.
//
//   channel   dir  handshake        payload
//   i_rx      in   valid/ready      rx_byte
//   o_res     out  valid/ready      kind, payload_byte, byte_index, frame_seq,
//                                   command_code, data_size
//   apb       in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One byte is taken per cycle while the skid entry is empty; its result, if any,
// is registered for o_res; the frame machine and checksum update per accepted byte.
// A two-entry output stage (result register plus skid register) lets input keep
// flowing while a result waits; i_rx.ready drops only while the skid entry is full.
// i_rst_n is synchronous, active low; it returns the machine to the sync hunt.
module framed_command_receiver_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fcr_rx_if.sink                       i_rx,
    fcr_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcr_pkg::PADDR_W-1:0]  paddr,
    input  logic [fcr_pkg::PDATA_W-1:0]  pwdata,
    output logic [fcr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import fcr_pkg::*;

    t_cfg    cfg;
    logic    take;
    logic    res_vld;
    t_result res;

    logic    r_out_vld;
    t_result r_out;
    logic    r_skd_vld;
    t_result r_skd;
    logic    out_free;

    fcr_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_rx.ready = ~r_skd_vld;
    assign take       = i_rx.valid & ~r_skd_vld;

    fcr_frame_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_take    (take),
        .i_byte    (i_rx.rx_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // Output register is free when empty or being taken this cycle
    assign out_free = ~r_out_vld | o_res.ready;

    // Valid flags of the output and skid stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skd_vld) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= take & res_vld;
            end
        end else if (take & res_vld) begin
            r_skd_vld <= 1'b1;
        end
    end

    // Payload of the output and skid stages
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skd_vld) r_out <= r_skd;
            else           r_out <= res;
        end else if (take & res_vld) begin
            r_skd <= res;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.kind         = r_out.kind;
    assign o_res.payload_byte = r_out.payload_byte;
    assign o_res.byte_index   = r_out.byte_index;
    assign o_res.frame_seq    = r_out.frame_seq;
    assign o_res.command_code = r_out.command_code;
    assign o_res.data_size    = r_out.data_size;
endmodule

>>> tb/sv/fcr_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for the framed command receiver: watches the byte channel,
// the result channel and APB writes, predicts every result and compares it.
// Depends on fcr_pkg, fcr_rx_if and fcr_res_if.
module fcr_frame_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fcr_rx_if                            rx_mon,
    fcr_res_if                           res_mon,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic                         i_pready,
    input  logic [fcr_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [fcr_pkg::PDATA_W-1:0]  i_pwdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import fcr_pkg::*;

    typedef logic [BYTE_W-1:0] t_octet;

    // Shadow of the registers
    t_octet  sync_a;
    t_octet  sync_b;
    t_octet  code_max;

    // Shadow of the deframer state
    t_phase  frame_phase;
    t_octet  seq_q;
    t_octet  len_q;
    t_octet  count_q;
    t_octet  csum_q;
    t_octet  code_q;

    t_result expected_results[$];
    int      fail_count;

    initial begin
        fail_count = 0;
    end

    // rotate left by three, then fold in the byte
    function automatic t_octet csum_step(input t_octet s, input t_octet b);
        return t_octet'((s << 3) | (s >> 5)) ^ b;
    endfunction

    function automatic t_result make_result(input t_kind k, input t_octet pay,
                                            input t_octet idx, input t_octet size);
        t_result r;
        r.kind         = k;
        r.payload_byte = pay;
        r.byte_index   = idx;
        r.frame_seq    = seq_q;
        r.command_code = (len_q == 8'd0) ? 8'd0 : code_q;
        r.data_size    = size;
        return r;
    endfunction

    // Advance the shadow deframer by one accepted byte
    task automatic deframe_byte(input t_octet b);
        t_octet pos;
        t_octet total;
        t_kind  k;
        case (frame_phase)
            ST_SYNC1: begin
                if (b == sync_a) frame_phase = ST_SYNC2;
            end
            ST_SYNC2: begin
                // second sync wins when both sync bytes are equal
                if (b == sync_b) frame_phase = ST_SEQ;
                else if (b != sync_a) frame_phase = ST_SYNC1;
            end
            ST_SEQ: begin
                seq_q       = b;
                frame_phase = ST_LEN;
            end
            ST_LEN: begin
                len_q   = b;
                count_q = 8'd0;
                csum_q  = 8'd0;
                if (b != 8'd0) frame_phase = ST_BODY;
                else frame_phase = ST_CSUM;
            end
            ST_BODY: begin
                pos    = count_q;
                csum_q = csum_step(csum_q, b);
                if (pos == 8'd0) begin
                    code_q = b;
                end else begin
                    expected_results.push_back(
                        make_result(KIND_PAYLOAD, b, pos - 8'd1, 8'd0));
                end
                count_q = pos + 8'd1;
                if (count_q >= len_q) frame_phase = ST_CSUM;
            end
            ST_CSUM: begin
                total       = csum_step(csum_q, b);
                csum_q      = total;
                frame_phase = ST_SYNC1;
                if (total != 8'd0) k = KIND_CSUM_ERR;
                else if (len_q == 8'd0 || code_q == 8'd0 || code_q >= code_max)
                    k = KIND_BAD_CMD;
                else k = KIND_FRAME_OK;
                expected_results.push_back(make_result(k, 8'd0, 8'd0,
                    (len_q == 8'd0) ? 8'd0 : len_q - 8'd1));
            end
            default: frame_phase = ST_SYNC1;
        endcase
    endtask

    task automatic note_mismatch(input bit have_want, input t_result want,
                                 input t_result seen);
        fail_count++;
        if (fail_count <= 10) begin
            if (have_want)
                $display("mismatch @%0t: expected kind %0d pay %02h idx %0d seq %02h code %02h size %0d",
                         $time, want.kind, want.payload_byte, want.byte_index,
                         want.frame_seq, want.command_code, want.data_size);
            else
                $display("mismatch @%0t: unexpected result", $time);
            $display("    got kind %0d pay %02h idx %0d seq %02h code %02h size %0d",
                     seen.kind, seen.payload_byte, seen.byte_index,
                     seen.frame_seq, seen.command_code, seen.data_size);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            sync_a      = 8'd0;
            sync_b      = 8'd0;
            code_max    = CODE_LIMIT_RST;
            frame_phase = ST_SYNC1;
            seq_q       = 8'd0;
            len_q       = 8'd0;
            count_q     = 8'd0;
            csum_q      = 8'd0;
            code_q      = 8'd0;
            expected_results.delete();
        end else begin
            // register writes land on the access cycle
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_SYNC_FIRST:  sync_a   = i_pwdata[BYTE_W-1:0];
                    REG_SYNC_SECOND: sync_b   = i_pwdata[BYTE_W-1:0];
                    REG_CODE_LIMIT:  code_max = i_pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end

            if (rx_mon.valid && rx_mon.ready) deframe_byte(rx_mon.rx_byte);

            // compare each result request with the oldest prediction
            if (res_mon.valid && res_mon.ready) begin
                seen.kind         = t_kind'(res_mon.kind);
                seen.payload_byte = res_mon.payload_byte;
                seen.byte_index   = res_mon.byte_index;
                seen.frame_seq    = res_mon.frame_seq;
                seen.command_code = res_mon.command_code;
                seen.data_size    = res_mon.data_size;
                if (expected_results.size() == 0) begin
                    note_mismatch(1'b0, seen, seen);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.kind != want.kind
                        || seen.payload_byte != want.payload_byte
                        || seen.byte_index != want.byte_index
                        || seen.frame_seq != want.frame_seq
                        || seen.command_code != want.command_code
                        || seen.data_size != want.data_size)
                        note_mismatch(1'b1, want, seen);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the framed command receiver testbench: clock, reset, APB writes,
// byte stimulus, result back-pressure and the verdict.
// Depends on fcr_pkg, fcr_rx_if, fcr_res_if, fcr_frame_checker and the block.
module testbench;
    import fcr_pkg::*;

    typedef logic [BYTE_W-1:0] t_octet;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 sent_bytes = 0;

    // stimulus view of the current register settings
    t_octet             tx_sync_a = 8'd0;
    t_octet             tx_sync_b = 8'd0;
    t_octet             tx_limit = CODE_LIMIT_RST;
    t_octet             tx_bytes[$];
    bit                 tx_steady = 1'b0;
    bit                 res_steady = 1'b0;
    bit                 hold_off_req = 1'b0;
    bit                 hold_off_done = 1'b0;

    fcr_rx_if  rx_ch();
    fcr_res_if res_ch();

    framed_command_receiver_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fcr_frame_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .rx_mon       (rx_ch),
        .res_mon      (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int tx_gap();
        int r;
        if (tx_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 4);
        if (r < 90) return $urandom_range(5, 16);
        return $urandom_range(17, 48);
    endfunction

    // bias codes toward the edges of the valid range
    function automatic t_octet frame_code();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return tx_limit - 8'd1;
            2: return tx_limit;
            3: return 8'hff;
            default: return (tx_limit > 8'd1) ? t_octet'($urandom_range(1, tx_limit - 1))
                                               : t_octet'($urandom);
        endcase
    endfunction

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input t_octet value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input t_octet first, input t_octet second, input t_octet lim);
        reg_write(REG_SYNC_FIRST, first);
        reg_write(REG_SYNC_SECOND, second);
        reg_write(REG_CODE_LIMIT, lim);
        tx_sync_a = first;
        tx_sync_b = second;
        tx_limit  = lim;
    endtask

    // Queue one frame; the checksum is right unless bad_sum is set
    task automatic add_frame(input t_octet seq, input int len, input t_octet code,
                             input bit bad_sum, input bit extra_sync);
        t_octet sum;
        t_octet b;
        t_octet chk;
        tx_bytes.push_back(tx_sync_a);
        if (extra_sync) tx_bytes.push_back(tx_sync_a);
        tx_bytes.push_back(tx_sync_b);
        tx_bytes.push_back(seq);
        tx_bytes.push_back(t_octet'(len));
        sum = 8'd0;
        for (int i = 0; i < len; i++) begin
            b = (i == 0) ? code : t_octet'($urandom);
            tx_bytes.push_back(b);
            sum = {sum[4:0], sum[7:5]} ^ b;
        end
        chk = {sum[4:0], sum[7:5]};
        if (bad_sum) chk = chk ^ t_octet'($urandom_range(1, 255));
        tx_bytes.push_back(chk);
    endtask

    // Offer every queued byte, one request per handshake
    task automatic send_bytes();
        int gap;
        while (tx_bytes.size() != 0) begin
            gap = tx_gap();
            if (gap != 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= tx_bytes.pop_front();
            @(posedge i_clk);
            while (!rx_ch.ready) @(posedge i_clk);
            sent_bytes++;
        end
    endtask

    // Let every predicted result arrive before touching registers
    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int goal);
        int start;
        int r;
        int len;
        start = sent_bytes;
        while (sent_bytes - start < goal) begin
            if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
            r = $urandom_range(0, 99);
            if (r < 78) begin
                add_frame(t_octet'($urandom), frame_len(), frame_code(),
                          $urandom_range(0, 6) == 0,
                          tx_sync_a != tx_sync_b && $urandom_range(0, 4) == 0);
            end else if (r < 88) begin
                // sync broken after the first byte
                tx_bytes.push_back(tx_sync_a);
                tx_bytes.push_back(t_octet'($urandom));
            end else if (r < 95) begin
                // frame cut short; the next frame's bytes land in its body
                len = $urandom_range(3, 12);
                tx_bytes.push_back(tx_sync_a);
                tx_bytes.push_back(tx_sync_b);
                tx_bytes.push_back(t_octet'($urandom));
                tx_bytes.push_back(t_octet'(len));
                repeat ($urandom_range(0, len - 1)) tx_bytes.push_back(t_octet'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) tx_bytes.push_back(t_octet'($urandom));
            end
            send_bytes();
        end
    endtask

    // Result side: random stalls, one long hold-off to back the block up
    initial begin : res_side
        int stall;
        int r;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) res_steady = !res_steady;
            r = $urandom_range(0, 99);
            if (res_steady || r < 65) stall = 0;
            else if (r < 90) stall = $urandom_range(1, 3);
            else stall = $urandom_range(10, 40);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: both sync bytes zero, code limit 128
        random_traffic(20);
        drain();

        set_config(8'ha5, 8'h5a, 8'd16);
        // directed: noise, repeated first sync with an empty frame
        tx_bytes.push_back(8'h00);
        add_frame(8'hff, 0, 8'd0, 1'b0, 1'b1);
        add_frame(8'h00, 2, 8'd15, 1'b0, 1'b0);
        tx_bytes.push_back(8'ha5);
        tx_bytes.push_back(8'h3c);
        add_frame(8'h01, 1, 8'd0, 1'b0, 1'b0);
        add_frame(8'h7f, 2, 8'd3, 1'b1, 1'b0);
        add_frame(8'h55, 0, 8'd0, 1'b1, 1'b0);
        send_bytes();
        // long payload frame while the result side holds off
        hold_off_req = 1'b1;
        add_frame(8'h42, 40, 8'd7, 1'b0, 1'b0);
        send_bytes();
        random_traffic(30);
        drain();

        // equal sync bytes, every code rejected
        set_config(8'hff, 8'hff, 8'd1);
        random_traffic(15);
        drain();

        set_config(8'h00, 8'hff, CODE_LIMIT_RST);
        add_frame(8'hc3, 255, 8'd1, 1'b0, 1'b0);
        send_bytes();
        random_traffic(15);
        drain();

        set_config(t_octet'($urandom), t_octet'($urandom), t_octet'($urandom_range(1, 128)));
        random_traffic(15);
        drain();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

endmodule
